// ----- sv/mbtcp_pkg.sv -----
// Shared constants, codes and types for the Modbus TCP read request parser.
`default_nettype none
package mbtcp_pkg;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic CSR_MAX_QUANTITY = 1'b0;
   localparam logic CSR_MAP_SIZE     = 1'b1;

   localparam logic [6:0]  MAX_QUANTITY_RESET = 7'd16;
   localparam logic [15:0] MAP_SIZE_RESET     = 16'd16;

   localparam logic [3:0]  LAST_POS     = 4'd11;
   localparam logic [3:0]  COUNT_MAX    = 4'd15;
   localparam logic [15:0] MBAP_LEN     = 16'd6;
   localparam logic [7:0]  FUNC_HOLDING = 8'h03;
   localparam logic [7:0]  FUNC_INPUT   = 8'h04;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_MALFORMED = 3'd1;
   localparam logic [2:0] ERR_FUNCTION  = 3'd2;
   localparam logic [2:0] ERR_ADDRESS   = 3'd3;
   localparam logic [2:0] ERR_VALUE     = 3'd4;

   localparam logic [3:0] POS_TRANS_HI = 4'd0;
   localparam logic [3:0] POS_TRANS_LO = 4'd1;
   localparam logic [3:0] POS_PROTO_HI = 4'd2;
   localparam logic [3:0] POS_PROTO_LO = 4'd3;
   localparam logic [3:0] POS_LEN_HI   = 4'd4;
   localparam logic [3:0] POS_LEN_LO   = 4'd5;
   localparam logic [3:0] POS_UNIT     = 4'd6;
   localparam logic [3:0] POS_FUNC     = 4'd7;
   localparam logic [3:0] POS_START_HI = 4'd8;
   localparam logic [3:0] POS_START_LO = 4'd9;
   localparam logic [3:0] POS_QTY_HI   = 4'd10;
   localparam logic [3:0] POS_QTY_LO   = 4'd11;

   typedef struct packed {
      logic [15:0] transaction_id;
      logic [7:0]  unit_id;
      logic [7:0]  function_code;
      logic [15:0] start_address;
      logic [15:0] quantity;
      logic [15:0] header_length;
      logic        protocol_nonzero;
      logic        length_ok;
   } frame_type;

endpackage
`default_nettype wire

// ----- sv/mbtcp_verdict.sv -----
// Verdict logic: ranks the frame checks and yields one error code.
`default_nettype none
module mbtcp_verdict (
   input  mbtcp_pkg::frame_type frame,
   input  logic [6:0]           max_quantity,
   input  logic [15:0]          map_size,
   output logic [2:0]           error_code
);
   import mbtcp_pkg::*;

   logic        malformed;
   logic        bad_function;
   logic        bad_value;
   logic [16:0] end_address;
   logic        bad_address;

   assign malformed = !frame.length_ok || frame.protocol_nonzero ||
                      (frame.header_length != MBAP_LEN) || (frame.unit_id == 8'd0);
   assign bad_function = (frame.function_code != FUNC_HOLDING) &&
                         (frame.function_code != FUNC_INPUT);
   assign bad_value = (frame.quantity == 16'd0) ||
                      (frame.quantity > {9'd0, max_quantity});
   assign end_address = {1'b0, frame.start_address} + {1'b0, frame.quantity};
   assign bad_address = end_address > {1'b0, map_size};

   always_comb begin
      if (malformed) begin
         error_code = ERR_MALFORMED;
      end else if (bad_function) begin
         error_code = ERR_FUNCTION;
      end else if (bad_value) begin
         error_code = ERR_VALUE;
      end else if (bad_address) begin
         error_code = ERR_ADDRESS;
      end else begin
         error_code = ERR_OK;
      end
   end

endmodule
`default_nettype wire

// ----- sv/modbus_tcp_read_request_parser.sv -----
// Modbus TCP read request parser: byte capture, verdict and result register.
//
// Usage: the req channel carries one frame byte per transaction, with
// req_last_byte set on the final byte of a frame. Non-final bytes produce
// nothing; the final byte produces one rsp transaction holding the error
// code and the captured fields (all zero for a malformed frame).
// The final byte passes through the input register and then the result register,
// whose output is rsp_valid; a pending result holds it in the input register.
// Throughput: one byte per cycle while no final byte waits; the only per-byte
// work is a capture by position and, on the final byte, one 17-bit add and compare.
// When rsp_ready is low with a result pending, the final byte of the next
// frame waits in the input register and req_ready drops; earlier bytes of
// that frame still flow.
// Reset clears the frame state, drops any pending transaction and loads
// max_quantity = 16 and map_size = 16. The csr_ port is APB-style, with
// max_quantity at address 0 and map_size at address 4; pready is always
// high. Write registers only while no frame is in flight.
`default_nettype none
module modbus_tcp_read_request_parser (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_frame_byte,
   input  logic                             req_last_byte,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [2:0]                       rsp_error_code,
   output logic [15:0]                      rsp_transaction_id,
   output logic [7:0]                       rsp_unit_id,
   output logic [7:0]                       rsp_function_code,
   output logic [15:0]                      rsp_start_address,
   output logic [15:0]                      rsp_quantity,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [mbtcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mbtcp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mbtcp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                             csr_pready
);
   import mbtcp_pkg::*;

   logic [6:0]  max_quantity_ff;
   logic [15:0] map_size_ff;
   logic        csr_write;

   logic        s1_valid_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic        s1_move;
   logic        rsp_free;

   logic [3:0]  byte_count_ff;
   logic        protocol_nonzero_ff, protocol_nonzero_in;
   logic [15:0] header_length_ff, header_length_in;
   logic [15:0] transaction_ff, transaction_in;
   logic [7:0]  unit_ff, unit_in;
   logic [7:0]  function_ff, function_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] quantity_ff, quantity_in;

   frame_type   frame;
   logic [2:0]  verdict;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_error_ff;
   logic [15:0] rsp_transaction_ff;
   logic [7:0]  rsp_unit_ff;
   logic [7:0]  rsp_function_ff;
   logic [15:0] rsp_start_ff;
   logic [15:0] rsp_quantity_ff;

   // configuration registers
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_quantity_ff <= MAX_QUANTITY_RESET;
         map_size_ff     <= MAP_SIZE_RESET;
      end else if (csr_write) begin
         unique case (csr_paddr[2])
            CSR_MAX_QUANTITY: max_quantity_ff <= csr_pwdata[6:0];
            CSR_MAP_SIZE:     map_size_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         CSR_MAX_QUANTITY: csr_prdata = {{(CSR_DATA_W-7){1'b0}}, max_quantity_ff};
         CSR_MAP_SIZE:     csr_prdata = {{(CSR_DATA_W-16){1'b0}}, map_size_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // input register
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_ready = !s1_valid_ff || s1_move;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_byte_ff <= req_frame_byte;
         s1_last_ff <= req_last_byte;
      end
   end

   // capture by byte position
   always_comb begin
      protocol_nonzero_in = protocol_nonzero_ff;
      header_length_in    = header_length_ff;
      transaction_in      = transaction_ff;
      unit_in             = unit_ff;
      function_in         = function_ff;
      start_in            = start_ff;
      quantity_in         = quantity_ff;
      case (byte_count_ff)
         POS_TRANS_HI: transaction_in   = {s1_byte_ff, transaction_ff[7:0]};
         POS_TRANS_LO: transaction_in   = {transaction_ff[15:8], s1_byte_ff};
         POS_PROTO_HI, POS_PROTO_LO:
                       protocol_nonzero_in = protocol_nonzero_ff || (s1_byte_ff != 8'd0);
         POS_LEN_HI:   header_length_in = {s1_byte_ff, header_length_ff[7:0]};
         POS_LEN_LO:   header_length_in = {header_length_ff[15:8], s1_byte_ff};
         POS_UNIT:     unit_in          = s1_byte_ff;
         POS_FUNC:     function_in      = s1_byte_ff;
         POS_START_HI: start_in         = {s1_byte_ff, start_ff[7:0]};
         POS_START_LO: start_in         = {start_ff[15:8], s1_byte_ff};
         POS_QTY_HI:   quantity_in      = {s1_byte_ff, quantity_ff[7:0]};
         POS_QTY_LO:   quantity_in      = {quantity_ff[15:8], s1_byte_ff};
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff       <= '0;
         protocol_nonzero_ff <= 1'b0;
         header_length_ff    <= '0;
         transaction_ff      <= '0;
         unit_ff             <= '0;
         function_ff         <= '0;
         start_ff            <= '0;
         quantity_ff         <= '0;
      end else if (s1_move) begin
         if (s1_last_ff) begin
            byte_count_ff       <= '0;
            protocol_nonzero_ff <= 1'b0;
            header_length_ff    <= '0;
            transaction_ff      <= '0;
            unit_ff             <= '0;
            function_ff         <= '0;
            start_ff            <= '0;
            quantity_ff         <= '0;
         end else begin
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_ff <= byte_count_ff + 4'd1;
            end
            protocol_nonzero_ff <= protocol_nonzero_in;
            header_length_ff    <= header_length_in;
            transaction_ff      <= transaction_in;
            unit_ff             <= unit_in;
            function_ff         <= function_in;
            start_ff            <= start_in;
            quantity_ff         <= quantity_in;
         end
      end
   end

   // verdict on the final byte
   assign frame.transaction_id   = transaction_in;
   assign frame.unit_id          = unit_in;
   assign frame.function_code    = function_in;
   assign frame.start_address    = start_in;
   assign frame.quantity         = quantity_in;
   assign frame.header_length    = header_length_in;
   assign frame.protocol_nonzero = protocol_nonzero_in;
   assign frame.length_ok        = (byte_count_ff == LAST_POS);

   mbtcp_verdict u_verdict (
      .frame        (frame),
      .max_quantity (max_quantity_ff),
      .map_size     (map_size_ff),
      .error_code   (verdict)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move && s1_last_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move && s1_last_ff) begin
         rsp_error_ff <= verdict;
         if (verdict == ERR_MALFORMED) begin
            rsp_transaction_ff <= '0;
            rsp_unit_ff        <= '0;
            rsp_function_ff    <= '0;
            rsp_start_ff       <= '0;
            rsp_quantity_ff    <= '0;
         end else begin
            rsp_transaction_ff <= frame.transaction_id;
            rsp_unit_ff        <= frame.unit_id;
            rsp_function_ff    <= frame.function_code;
            rsp_start_ff       <= frame.start_address;
            rsp_quantity_ff    <= frame.quantity;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_error_code     = rsp_error_ff;
   assign rsp_transaction_id = rsp_transaction_ff;
   assign rsp_unit_id        = rsp_unit_ff;
   assign rsp_function_code  = rsp_function_ff;
   assign rsp_start_address  = rsp_start_ff;
   assign rsp_quantity       = rsp_quantity_ff;

endmodule
`default_nettype wire
